[hw/rtl/assert_macros.svh]
// Assertion macros used by the RTL of the SHA-1 digest block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be seen at a rising clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) else $error(msg);

`endif

[hw/rtl/sha1_pkg.sv]
// Constants, widths and helper functions of the SHA-1 digest block.
package sha1_pkg;

  localparam int WORD_W       = 32;
  localparam int BYTE_W       = 8;
  localparam int COUNT_W      = 61;
  localparam int ROUND_W      = 7;
  localparam int ROUNDS       = 80;
  localparam int WINDOW_WORDS = 16;
  localparam int DIGEST_WORDS = 5;
  localparam int INDEX_W      = 3;
  localparam int BLK_POS_W    = 6;
  localparam int LEN_POS      = 56;
  localparam int IN_DATA_W    = 8;
  localparam int OUT_DATA_W   = 40;

  localparam logic [WORD_W-1:0] H_INIT [DIGEST_WORDS] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  localparam logic [WORD_W-1:0] K_0 = 32'h5A827999;
  localparam logic [WORD_W-1:0] K_1 = 32'h6ED9EBA1;
  localparam logic [WORD_W-1:0] K_2 = 32'h8F1BBCDC;
  localparam logic [WORD_W-1:0] K_3 = 32'hCA62C1D6;

  localparam logic [BYTE_W-1:0] PAD_BYTE = 8'h80;

  function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] x, input int n);
    rotl = (x << n) | (x >> (WORD_W - n));
  endfunction

endpackage

[hw/rtl/sha1_message_digest.sv]
// Streaming SHA-1 digest engine with byte packing, padding and digest output.

// Message bytes are taken one per cycle while the block is idle and are packed big-endian
// into a 16-word schedule window that works as a shift line. Every 64th byte starts the
// compression: one shared round unit runs 80 rounds at one round per cycle, then the add
// state adds the working words into the chain words. An item with tlast set runs the
// padding through the same byte path, one padding byte per cycle, up to the end of the
// block (and of a second block when the length no longer fits), each block followed by
// its compression; the five digest words then follow, h0 first, the fifth one with tlast
// set. tready is low during every compression, and from the start of the padding until
// the last digest word has been taken.
`include "assert_macros.svh"

module sha1_message_digest (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // [7:0] data_byte
  input  logic [sha1_pkg::IN_DATA_W-1:0]    s_axis_tdata_i,
  // [0] has_byte
  input  logic                              s_axis_tuser_i,
  input  logic                              s_axis_tlast_i,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // [31:0] digest_word, [34:32] word_index, [39:35] zero
  output logic [sha1_pkg::OUT_DATA_W-1:0]   m_axis_tdata_o,
  output logic                              m_axis_tlast_o
);
  import sha1_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_ADD,
    ST_OUT
  } state_e;

  state_e                 state_q, state_d;
  logic [COUNT_W-1:0]     msg_count_q, msg_count_d;
  logic [BLK_POS_W-1:0]   blk_pos_q, blk_pos_d;
  logic [ROUND_W-1:0]     round_q, round_d;
  logic [INDEX_W-1:0]     out_idx_q, out_idx_d;
  logic                   in_pad_q, in_pad_d;
  logic                   sent80_q, sent80_d;
  logic                   pad_extra_q, pad_extra_d;
  logic                   final_q, final_d;
  logic [WORD_W-1:0]      chain_q [DIGEST_WORDS];
  logic [WORD_W-1:0]      chain_d [DIGEST_WORDS];

  logic [WORD_W-1:0]      word_q;
  logic [WORD_W-1:0]      win_q [WINDOW_WORDS];
  logic [WORD_W-1:0]      work_q [DIGEST_WORDS];

  logic                   in_accept;
  logic                   out_accept;
  logic                   byte_we;
  logic [BYTE_W-1:0]      byte_val;
  logic                   start_comp;
  logic                   extra_next;
  logic [63:0]            bit_len;
  logic [2:0]             len_sel;
  logic [BYTE_W-1:0]      len_byte;
  logic [BYTE_W-1:0]      pad_byte;
  logic [WORD_W-1:0]      f_val, k_val, tmp_val, sched_val;
  logic                   blk_end;

  assign in_accept  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_accept = m_axis_tvalid_o && m_axis_tready_i;
  assign blk_end    = (blk_pos_q == BLK_POS_W'(63));

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = (state_q == ST_OUT);
  assign m_axis_tlast_o  = (out_idx_q == INDEX_W'(DIGEST_WORDS - 1));
  assign m_axis_tdata_o  = {5'b00000, out_idx_q, chain_q[out_idx_q]};

  // Length bytes go out big-endian at block positions 56 to 63.
  assign bit_len  = {msg_count_q, 3'b000};
  assign len_sel  = ~blk_pos_q[2:0];
  assign len_byte = bit_len[{len_sel, 3'b000} +: 8];
  assign extra_next = sent80_q ? pad_extra_q : (blk_pos_q >= BLK_POS_W'(LEN_POS));

  always_comb begin
    if (!sent80_q) begin
      pad_byte = PAD_BYTE;
    end else if (!pad_extra_q && (blk_pos_q >= BLK_POS_W'(LEN_POS))) begin
      pad_byte = len_byte;
    end else begin
      pad_byte = '0;
    end
  end

  // Shared round unit: work_q holds a..e, win_q[0] holds the schedule word of this round.
  always_comb begin
    if (round_q < ROUND_W'(20)) begin
      f_val = (work_q[1] & work_q[2]) | (~work_q[1] & work_q[3]);
      k_val = K_0;
    end else if (round_q < ROUND_W'(40)) begin
      f_val = work_q[1] ^ work_q[2] ^ work_q[3];
      k_val = K_1;
    end else if (round_q < ROUND_W'(60)) begin
      f_val = (work_q[1] & work_q[2]) | (work_q[1] & work_q[3]) | (work_q[2] & work_q[3]);
      k_val = K_2;
    end else begin
      f_val = work_q[1] ^ work_q[2] ^ work_q[3];
      k_val = K_3;
    end
  end

  assign tmp_val   = rotl(work_q[0], 5) + f_val + work_q[4] + k_val + win_q[0];
  assign sched_val = rotl(win_q[13] ^ win_q[8] ^ win_q[2] ^ win_q[0], 1);

  always_comb begin
    state_d     = state_q;
    msg_count_d = msg_count_q;
    blk_pos_d   = blk_pos_q;
    round_d     = round_q;
    out_idx_d   = out_idx_q;
    in_pad_d    = in_pad_q;
    sent80_d    = sent80_q;
    pad_extra_d = pad_extra_q;
    final_d     = final_q;
    chain_d     = chain_q;
    byte_we     = 1'b0;
    byte_val    = s_axis_tdata_i;
    start_comp  = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          if (s_axis_tuser_i) begin
            byte_we     = 1'b1;
            msg_count_d = msg_count_q + COUNT_W'(1);
          end
          if (s_axis_tlast_i) begin
            in_pad_d = 1'b1;
            sent80_d = 1'b0;
          end
          if (s_axis_tuser_i && blk_end) begin
            start_comp = 1'b1;
            state_d    = ST_ROUND;
          end else if (s_axis_tlast_i) begin
            state_d = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        byte_we  = 1'b1;
        byte_val = pad_byte;
        sent80_d = 1'b1;
        if (!sent80_q) begin
          pad_extra_d = extra_next;
        end
        if (blk_end) begin
          start_comp  = 1'b1;
          final_d     = !extra_next;
          pad_extra_d = 1'b0;
          state_d     = ST_ROUND;
        end
      end
      ST_ROUND: begin
        if (round_q == ROUND_W'(ROUNDS - 1)) begin
          round_d = '0;
          state_d = ST_ADD;
        end else begin
          round_d = round_q + ROUND_W'(1);
        end
      end
      ST_ADD: begin
        for (int i = 0; i < DIGEST_WORDS; i++) begin
          chain_d[i] = chain_q[i] + work_q[i];
        end
        if (final_q) begin
          out_idx_d = '0;
          state_d   = ST_OUT;
        end else if (in_pad_q) begin
          state_d = ST_PAD;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_OUT: begin
        if (out_accept) begin
          if (m_axis_tlast_o) begin
            chain_d     = H_INIT;
            msg_count_d = '0;
            blk_pos_d   = '0;
            out_idx_d   = '0;
            in_pad_d    = 1'b0;
            sent80_d    = 1'b0;
            final_d     = 1'b0;
            state_d     = ST_IDLE;
          end else begin
            out_idx_d = out_idx_q + INDEX_W'(1);
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (byte_we) begin
      blk_pos_d = blk_pos_q + BLK_POS_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      msg_count_q <= '0;
      blk_pos_q   <= '0;
      round_q     <= '0;
      out_idx_q   <= '0;
      in_pad_q    <= 1'b0;
      sent80_q    <= 1'b0;
      pad_extra_q <= 1'b0;
      final_q     <= 1'b0;
      chain_q     <= H_INIT;
    end else begin
      state_q     <= state_d;
      msg_count_q <= msg_count_d;
      blk_pos_q   <= blk_pos_d;
      round_q     <= round_d;
      out_idx_q   <= out_idx_d;
      in_pad_q    <= in_pad_d;
      sent80_q    <= sent80_d;
      pad_extra_q <= pad_extra_d;
      final_q     <= final_d;
      chain_q     <= chain_d;
    end
  end

  // Datapath registers: packer word, schedule shift line and round words.
  always_ff @(posedge clk_i) begin
    if (byte_we) begin
      word_q <= {word_q[WORD_W-BYTE_W-1:0], byte_val};
      if (blk_pos_q[1:0] == 2'b11) begin
        for (int i = 0; i < WINDOW_WORDS - 1; i++) begin
          win_q[i] <= win_q[i+1];
        end
        win_q[WINDOW_WORDS-1] <= {word_q[WORD_W-BYTE_W-1:0], byte_val};
      end
    end else if (state_q == ST_ROUND) begin
      for (int i = 0; i < WINDOW_WORDS - 1; i++) begin
        win_q[i] <= win_q[i+1];
      end
      win_q[WINDOW_WORDS-1] <= sched_val;
    end

    if (start_comp) begin
      work_q <= chain_q;
    end else if (state_q == ST_ROUND) begin
      work_q[0] <= tmp_val;
      work_q[1] <= work_q[0];
      work_q[2] <= rotl(work_q[1], 30);
      work_q[3] <= work_q[2];
      work_q[4] <= work_q[3];
    end
  end

  `ASSERT_NEVER(a_no_overlap, clk_i, rst_ni, s_axis_tready_o && m_axis_tvalid_o, "input open during digest output")
  `ASSERT_CLK(a_round_range, clk_i, rst_ni, (state_q == ST_ROUND) |-> (round_q < ROUND_W'(ROUNDS)), "round counter out of range")
  `ASSERT_CLK(a_block_aligned, clk_i, rst_ni, (state_q == ST_ROUND) |-> (blk_pos_q == '0), "compression started off a block boundary")
  `ASSERT_CLK(a_digest_clear, clk_i, rst_ni, (out_accept && m_axis_tlast_o) |=> (state_q == ST_IDLE && msg_count_q == '0 && chain_q[0] == H_INIT[0]), "state not restored after digest")

endmodule

[tb/sha1_digest_checker.sv]
// Checker that predicts the SHA-1 digest of every message request and compares the output words.
`timescale 1ns / 1ps

module sha1_digest_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  // [7:0] data_byte
  input  logic [7:0]  s_tdata_i,
  // [0] has_byte
  input  logic        s_tuser_i,
  input  logic        s_tlast_i,
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  // [31:0] digest_word, [34:32] word_index, [39:35] zero
  input  logic [39:0] m_tdata_i,
  input  logic        m_tlast_i,
  input  logic        drain_done_i,
  output int          fail_count_o,
  output int          words_due_o,
  output int          words_checked_o
);

  typedef struct packed {
    logic [31:0] value;
    logic [2:0]  index;
    logic        final_word;
  } digest_word_t;

  logic [31:0]  chain_h [5];
  logic [7:0]   block_buf [64];
  logic [60:0]  msg_bytes;
  digest_word_t digest_due [$];
  int           mismatches = 0;
  int           words_checked = 0;
  bit           leftovers_reported = 1'b0;

  function automatic logic [31:0] rotate_left(input logic [31:0] x, input int unsigned n);
    logic [63:0] twice;
    twice = {x, x} << n;
    return twice[63:32];
  endfunction

  function automatic void restart_chain();
    for (int i = 0; i < 5; i++) chain_h[i] = sha1_pkg::H_INIT[i];
    msg_bytes = '0;
  endfunction

  // Runs the 80 rounds over the 64 buffered bytes and folds the result into the chain.
  function automatic void compress_buffer();
    logic [31:0] w [16];
    logic [31:0] a, b, c, d, e, f, k, t;
    for (int i = 0; i < 16; i++) begin
      w[i] = {block_buf[4*i], block_buf[4*i+1], block_buf[4*i+2], block_buf[4*i+3]};
    end
    a = chain_h[0];
    b = chain_h[1];
    c = chain_h[2];
    d = chain_h[3];
    e = chain_h[4];
    for (int r = 0; r < 80; r++) begin
      if (r >= 16) begin
        w[r & 15] = rotate_left(w[(r - 3) & 15] ^ w[(r - 8) & 15] ^ w[(r - 14) & 15] ^
                                w[r & 15], 1);
      end
      if (r < 20) begin
        f = (b & c) | (~b & d);
        k = sha1_pkg::K_0;
      end else if (r < 40) begin
        f = b ^ c ^ d;
        k = sha1_pkg::K_1;
      end else if (r < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = sha1_pkg::K_2;
      end else begin
        f = b ^ c ^ d;
        k = sha1_pkg::K_3;
      end
      t = rotate_left(a, 5) + f + e + k + w[r & 15];
      e = d;
      d = c;
      c = rotate_left(b, 30);
      b = a;
      a = t;
    end
    chain_h[0] += a;
    chain_h[1] += b;
    chain_h[2] += c;
    chain_h[3] += d;
    chain_h[4] += e;
  endfunction

  function automatic void take_request(input logic [7:0] data, input logic has,
                                       input logic last);
    int           pos;
    logic [63:0]  bit_len;
    digest_word_t beat;
    if (has) begin
      pos = int'(msg_bytes[5:0]);
      block_buf[pos] = data;
      msg_bytes++;
      if (pos == 63) compress_buffer();
    end
    if (last) begin
      pos = int'(msg_bytes[5:0]);
      block_buf[pos] = sha1_pkg::PAD_BYTE;
      pos++;
      // No room left for the length: close this block and pad a fresh one.
      if (pos > sha1_pkg::LEN_POS) begin
        while (pos < 64) begin
          block_buf[pos] = 8'h00;
          pos++;
        end
        compress_buffer();
        pos = 0;
      end
      while (pos < sha1_pkg::LEN_POS) begin
        block_buf[pos] = 8'h00;
        pos++;
      end
      bit_len = {msg_bytes, 3'b000};
      for (int i = 0; i < 8; i++) block_buf[sha1_pkg::LEN_POS + i] = bit_len[63 - 8*i -: 8];
      compress_buffer();
      for (int i = 0; i < 5; i++) begin
        beat.value      = chain_h[i];
        beat.index      = 3'(i);
        beat.final_word = (i == 4);
        digest_due.push_back(beat);
      end
      restart_chain();
    end
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t ns: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_word(input logic [39:0] tdata, input logic tlast);
    digest_word_t due;
    if (digest_due.size() == 0) begin
      report_mismatch($sformatf("digest word %h arrived with nothing expected", tdata[31:0]));
      return;
    end
    due = digest_due.pop_front();
    words_checked++;
    if (tdata[31:0] !== due.value)
      report_mismatch($sformatf("word %0d is %h, expected %h", due.index, tdata[31:0],
                                due.value));
    if (tdata[34:32] !== due.index)
      report_mismatch($sformatf("word index is %0d, expected %0d", tdata[34:32], due.index));
    if (tlast !== due.final_word)
      report_mismatch($sformatf("tlast on word %0d is %b, expected %b", due.index, tlast,
                                due.final_word));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      restart_chain();
      digest_due.delete();
    end else begin
      if (m_tvalid_i && m_tready_i) check_word(m_tdata_i, m_tlast_i);
      if (s_tvalid_i && s_tready_i) take_request(s_tdata_i, s_tuser_i, s_tlast_i);
      if (drain_done_i && !leftovers_reported) begin
        leftovers_reported = 1'b1;
        while (digest_due.size() != 0) begin
          report_mismatch($sformatf("digest word %0d never arrived",
                                    digest_due[0].index));
          void'(digest_due.pop_front());
        end
      end
      fail_count_o    <= mismatches;
      words_due_o     <= digest_due.size();
      words_checked_o <= words_checked;
    end
  end

endmodule

[tb/testbench.sv]
// Top of the SHA-1 digest testbench: clock, reset, message stimulus, output stalls and verdict.
`timescale 1ns / 1ps

module testbench;

  localparam int IDLE_LIMIT   = 5000;
  localparam int HOLD_CYCLES  = 800;
  localparam int RANDOM_ITEMS = 420;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        s_tvalid   = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata    = '0;
  logic        s_tuser    = 1'b0;
  logic        s_tlast    = 1'b0;
  logic        m_tvalid;
  logic        m_tready   = 1'b0;
  logic [39:0] m_tdata;
  logic        m_tlast;
  logic        hold_req   = 1'b0;
  logic        drain_done = 1'b0;

  int fail_count;
  int words_due;
  int words_checked;
  int burst_left    = 0;
  int requests_sent = 0;
  int messages_sent = 0;
  int longest       = 0;
  int idle_cycles   = 0;

  int boundary_lengths [9] = '{55, 56, 57, 63, 64, 65, 119, 120, 128};

  sha1_message_digest uut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tlast_o  (m_tlast)
  );

  sha1_digest_checker digest_check (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_tvalid_i      (s_tvalid),
    .s_tready_i      (s_tready),
    .s_tdata_i       (s_tdata),
    .s_tuser_i       (s_tuser),
    .s_tlast_i       (s_tlast),
    .m_tvalid_i      (m_tvalid),
    .m_tready_i      (m_tready),
    .m_tdata_i       (m_tdata),
    .m_tlast_i       (m_tlast),
    .drain_done_i    (drain_done),
    .fail_count_o    (fail_count),
    .words_due_o     (words_due),
    .words_checked_o (words_checked)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("No request accepted for %0d cycles", IDLE_LIMIT);
        $display("simulation failed");
        $finish;
      end
    end
  end

  // Output side: one long hold-off when asked, otherwise stall patterns that change often.
  initial begin
    int  phase_left;
    int  mode;
    bit  hold_done;
    phase_left = 0;
    mode       = 0;
    hold_done  = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        if (phase_left == 0) begin
          mode       = $urandom_range(0, 2);
          phase_left = $urandom_range(8, 80);
        end
        phase_left--;
        case (mode)
          0: m_tready <= 1'b1;
          1: m_tready <= 1'($urandom_range(0, 1));
          default: m_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Offers one request and waits for it to be taken; gaps fall between bursts.
  task automatic send_request(input logic [7:0] data, input logic has, input logic last);
    if (burst_left == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(80, 200)
                                                : $urandom_range(1, 24);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= data;
    s_tuser  <= has;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    burst_left--;
    if (has || last) requests_sent++;
  endtask

  task automatic pause_until_drained();
    s_tvalid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (words_due != 0);
  endtask

  task automatic send_message(input int len, input bit empty_last);
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 19) == 0) send_request(8'($urandom), 1'b0, 1'b0);
      case ($urandom_range(0, 7))
        0: b = 8'h00;
        1: b = 8'hFF;
        default: b = 8'($urandom);
      endcase
      send_request(b, 1'b1, (i == len - 1) && !empty_last);
    end
    if (len == 0 || empty_last) send_request(8'($urandom), 1'b0, 1'b1);
    messages_sent++;
    if (len > longest) longest = len;
  endtask

  initial begin
    int  len;
    bit  paused_mid;
    paused_mid = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty message: a last request that carries no byte.
    send_request(8'hFF, 1'b0, 1'b1);
    send_request(8'h61, 1'b1, 1'b0);
    send_request(8'h62, 1'b1, 1'b0);
    send_request(8'h63, 1'b1, 1'b1);
    // An ignored request in the middle of a message, then an empty final request.
    send_request(8'h00, 1'b1, 1'b0);
    send_request(8'hFF, 1'b0, 1'b0);
    send_request(8'hFF, 1'b1, 1'b0);
    send_request(8'h00, 1'b0, 1'b1);
    send_request(8'hFF, 1'b1, 1'b1);
    send_request(8'h00, 1'b1, 1'b1);
    messages_sent += 5;
    longest = 3;
    pause_until_drained();

    hold_req <= 1'b1;
    while (requests_sent < RANDOM_ITEMS) begin
      if (!paused_mid && requests_sent >= RANDOM_ITEMS / 2) begin
        pause_until_drained();
        paused_mid = 1'b1;
      end
      if ($urandom_range(0, 99) < 80) len = $urandom_range(0, 12);
      else len = boundary_lengths[$urandom_range(0, 8)];
      send_message(len, 1'($urandom_range(0, 1)));
    end

    pause_until_drained();
    repeat (400) @(posedge clk);
    drain_done <= 1'b1;
    repeat (2) @(posedge clk);
    $display("Hashed %0d messages from %0d requests, longest %0d bytes, with padding",
             messages_sent, requests_sent, longest);
    $display("into one and two extra blocks; %0d digest words compared.", words_checked);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
